/* hw/rtl/cpualu_pkg.sv */
// shared types and constants for the sm83 alu with flags
// operation codes, flag bit positions and request/response structs; no dependencies

package cpualu_pkg;

  // operation codes carried on the input tuser
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLCA  = 5'd10,
    OP_RRCA  = 5'd11,
    OP_RLA   = 5'd12,
    OP_RRA   = 5'd13,
    OP_CPL   = 5'd14,
    OP_SCF   = 5'd15,
    OP_CCF   = 5'd16,
    OP_DAA   = 5'd17,
    OP_ADD16 = 5'd18,
    OP_INC16 = 5'd19,
    OP_DEC16 = 5'd20
  } op_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_MAX = 8'h99;
  localparam logic [3:0] DAA_LO_MAX = 4'h9;

  // payload widths on the stream ports
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  // one alu request
  typedef struct packed {
    logic [4:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [3:0]  flags_in;
  } alu_req_t;

  // one alu response
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } alu_rsp_t;

endpackage

/* hw/rtl/cpu_alu_with_flags_unit.sv */
// top level of the sm83 alu with flags: stream ports, input and result registers
// depends on cpualu_pkg and cpualu_core

// Each request carries an operation code on in_tuser and both operands plus the incoming
// Z,N,H,C flags on in_tdata; each request gives exactly one response with the result and
// the new flags on out_tdata. A request is registered on entry, passes the combinational alu
// datapath and lands in the result register, which drives out_tvalid, and one request is
// taken per cycle as long as the result side keeps up. The datapath between the two register
// stages is combinational; both stages hold their contents under back-pressure. Unused
// operation codes pass operand_a and the flags unchanged.

module cpu_alu_with_flags_unit
  import cpualu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: operand_a [15:0], operand_b [31:16], flags_in [35:32], zero pad [39:36]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type [4:0]
  input  logic [4:0]             in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: result [15:0], flags_out [19:16], zero pad [23:20]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  alu_req_t req_r;
  alu_req_t req_nxt;
  logic     req_vld_r;
  alu_rsp_t rsp_r;
  alu_rsp_t rsp_nxt;
  logic     rsp_vld_r;
  logic     rsp_load;
  logic     req_load;

  // stage enables: result stage frees when empty or drained, input stage follows
  assign rsp_load  = !rsp_vld_r || out_tready;
  assign req_load  = !req_vld_r || rsp_load;
  assign in_tready = req_load;

  // unpack an incoming request
  always_comb begin
    req_nxt.req_type  = in_tuser;
    req_nxt.operand_a = in_tdata[15:0];
    req_nxt.operand_b = in_tdata[31:16];
    req_nxt.flags_in  = in_tdata[35:32];
  end

  // alu datapath
  cpualu_core u_core (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  // valid bits of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      if (req_load) begin
        req_vld_r <= in_tvalid;
      end
      if (rsp_load) begin
        rsp_vld_r <= req_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_load && in_tvalid) begin
      req_r <= req_nxt;
    end
    if (rsp_load && req_vld_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_tvalid = rsp_vld_r;
  assign out_tdata  = {4'd0, rsp_r.flags_out, rsp_r.result};

endmodule

/* hw/rtl/cpualu_core.sv */
// combinational sm83 alu datapath: arithmetic, logic, rotates, daa and 16-bit ops
// depends on cpualu_pkg for operation codes, flag positions and structs

module cpualu_core
  import cpualu_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [15:0] a16;
  logic [15:0] b16;
  logic [3:0]  f;
  logic        cin;
  logic        use_c;
  logic        c_bit;
  logic [8:0]  add9;
  logic [4:0]  add_h5;
  logic [8:0]  sub9;
  logic [4:0]  sub_h5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        daa_hi;
  logic        daa_lo;
  logic        daa_c;
  logic [7:0]  daa_adj;
  logic [7:0]  daa8;
  logic [16:0] add17;
  logic [12:0] add_h13;
  logic [15:0] res;
  logic [3:0]  nf;

  assign a8    = req.operand_a[7:0];
  assign b8    = req.operand_b[7:0];
  assign a16   = req.operand_a;
  assign b16   = req.operand_b;
  assign f     = req.flags_in;
  assign cin   = f[FLAG_C];

  // carry-in only for adc and sbc
  assign use_c = (req.req_type == OP_ADC) || (req.req_type == OP_SBC);
  assign c_bit = use_c & cin;

  // shared 8-bit adder and subtractor with half-carry taps
  assign add9   = {1'b0, a8} + {1'b0, b8} + {8'd0, c_bit};
  assign add_h5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, c_bit};
  assign sub9   = {1'b0, a8} - {1'b0, b8} - {8'd0, c_bit};
  assign sub_h5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, c_bit};

  assign inc8 = a8 + 8'd1;
  assign dec8 = a8 - 8'd1;

  // decimal adjust: high digit fix first, low digit test is unaffected by it
  assign daa_hi  = f[FLAG_N] ? cin : (cin || (a8 > DAA_HI_MAX));
  assign daa_lo  = f[FLAG_N] ? f[FLAG_H] : (f[FLAG_H] || (a8[3:0] > DAA_LO_MAX));
  assign daa_adj = (daa_hi ? DAA_HI_ADJ : 8'h00) + (daa_lo ? DAA_LO_ADJ : 8'h00);
  assign daa8    = f[FLAG_N] ? (a8 - daa_adj) : (a8 + daa_adj);
  assign daa_c   = daa_hi;

  // 16-bit add with carry out of bit 11 and bit 15
  assign add17   = {1'b0, a16} + {1'b0, b16};
  assign add_h13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};

  // result and flag select
  always_comb begin
    res = a16;
    nf  = f;
    case (op_t'(req.req_type))
      OP_ADD, OP_ADC: begin
        res = {8'd0, add9[7:0]};
        nf  = {(add9[7:0] == 8'd0), 1'b0, add_h5[4], add9[8]};
      end
      OP_SUB, OP_SBC: begin
        res = {8'd0, sub9[7:0]};
        nf  = {(sub9[7:0] == 8'd0), 1'b1, sub_h5[4], sub9[8]};
      end
      OP_CP: begin
        res = a16;
        nf  = {(sub9[7:0] == 8'd0), 1'b1, sub_h5[4], sub9[8]};
      end
      OP_AND: begin
        res = {8'd0, a8 & b8};
        nf  = {((a8 & b8) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res = {8'd0, a8 ^ b8};
        nf  = {((a8 ^ b8) == 8'd0), 3'b000};
      end
      OP_OR: begin
        res = {8'd0, a8 | b8};
        nf  = {((a8 | b8) == 8'd0), 3'b000};
      end
      OP_INC: begin
        res = {8'd0, inc8};
        nf  = {(inc8 == 8'd0), 1'b0, (a8[3:0] == 4'hF), cin};
      end
      OP_DEC: begin
        res = {8'd0, dec8};
        nf  = {(dec8 == 8'd0), 1'b1, (a8[3:0] == 4'h0), cin};
      end
      OP_RLCA: begin
        res = {8'd0, a8[6:0], a8[7]};
        nf  = {3'b000, a8[7]};
      end
      OP_RRCA: begin
        res = {8'd0, a8[0], a8[7:1]};
        nf  = {3'b000, a8[0]};
      end
      OP_RLA: begin
        res = {8'd0, a8[6:0], cin};
        nf  = {3'b000, a8[7]};
      end
      OP_RRA: begin
        res = {8'd0, cin, a8[7:1]};
        nf  = {3'b000, a8[0]};
      end
      OP_CPL: begin
        res = {8'd0, ~a8};
        nf  = {f[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        nf = {f[FLAG_Z], 3'b001};
      end
      OP_CCF: begin
        nf = {f[FLAG_Z], 2'b00, ~cin};
      end
      OP_DAA: begin
        res = {8'd0, daa8};
        nf  = {(daa8 == 8'd0), f[FLAG_N], 1'b0, daa_c};
      end
      OP_ADD16: begin
        res = add17[15:0];
        nf  = {f[FLAG_Z], 1'b0, add_h13[12], add17[16]};
      end
      OP_INC16: begin
        res = a16 + 16'd1;
      end
      OP_DEC16: begin
        res = a16 - 16'd1;
      end
      default: begin
        res = a16;
        nf  = f;
      end
    endcase
  end

  assign rsp.result    = res;
  assign rsp.flags_out = nf;

endmodule

/* tb/cpu_alu_with_flags_unit_tb.sv */
// self-checking testbench for the sm83 alu with flags (cpu_alu_with_flags_unit)
// depends on cpualu_pkg and the rtl of the unit; needs no files or arguments

`timescale 1ns / 100ps

module cpu_alu_with_flags_unit_tb;
  import cpualu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned LONG_HOLD_LEN = 80;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam logic [4:0]  OP_LAST_USED  = OP_DEC16;
  localparam logic [4:0]  OP_CODE_MAX   = 5'd31;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [4:0]             in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  cpu_alu_with_flags_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // requests waiting to be sent and responses still owed by the unit
  alu_req_t    req_q[$];
  alu_rsp_t    owed_rsp_q[$];
  alu_req_t    cur_req = '0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  logic        no_idle = 1'b0;
  logic        long_hold_go = 1'b0;
  logic        long_hold_done = 1'b0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // expected response of the sm83 alu for one request
  function automatic alu_rsp_t sm83_alu_result(alu_req_t rq);
    logic [15:0] a16, b16, res;
    logic [7:0]  a8, b8, r8;
    logic [3:0]  f, nf;
    logic        cin, c;
    logic [8:0]  wide9;
    logic [4:0]  nib5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    alu_rsp_t    rsp;
    a16 = rq.operand_a;
    b16 = rq.operand_b;
    a8  = a16[7:0];
    b8  = b16[7:0];
    f   = rq.flags_in;
    cin = f[FLAG_C];
    res = a16;
    nf  = f;
    case (rq.req_type)
      OP_ADD, OP_ADC: begin
        c = (rq.req_type == OP_ADC) ? cin : 1'b0;
        wide9 = {1'b0, a8} + {1'b0, b8} + {8'h00, c};
        nib5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, c};
        res = {8'h00, wide9[7:0]};
        nf  = '0;
        nf[FLAG_Z] = (wide9[7:0] == 8'h00);
        nf[FLAG_H] = nib5[4];
        nf[FLAG_C] = wide9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        c = (rq.req_type == OP_SBC) ? cin : 1'b0;
        wide9 = {1'b0, a8} - {1'b0, b8} - {8'h00, c};
        nib5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, c};
        // compare keeps the full first operand
        res = (rq.req_type == OP_CP) ? a16 : {8'h00, wide9[7:0]};
        nf  = '0;
        nf[FLAG_Z] = (wide9[7:0] == 8'h00);
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = nib5[4];
        nf[FLAG_C] = wide9[8];
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (rq.req_type == OP_AND) r8 = a8 & b8;
        else if (rq.req_type == OP_XOR) r8 = a8 ^ b8;
        else r8 = a8 | b8;
        res = {8'h00, r8};
        nf  = '0;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_H] = (rq.req_type == OP_AND);
      end
      OP_INC, OP_DEC: begin
        r8  = (rq.req_type == OP_INC) ? a8 + 8'd1 : a8 - 8'd1;
        res = {8'h00, r8};
        nf  = '0;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = (rq.req_type == OP_DEC);
        nf[FLAG_H] = (rq.req_type == OP_INC) ? (a8[3:0] == 4'hF) : (a8[3:0] == 4'h0);
        nf[FLAG_C] = cin;
      end
      // rotates of a clear z, n and h; carry takes the bit shifted out
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (rq.req_type)
          OP_RLCA: r8 = {a8[6:0], a8[7]};
          OP_RRCA: r8 = {a8[0], a8[7:1]};
          OP_RLA:  r8 = {a8[6:0], cin};
          default: r8 = {cin, a8[7:1]};
        endcase
        res = {8'h00, r8};
        nf  = '0;
        nf[FLAG_C] = (rq.req_type == OP_RLCA || rq.req_type == OP_RLA) ? a8[7] : a8[0];
      end
      OP_CPL: begin
        res = {8'h00, ~a8};
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        nf = '0;
        nf[FLAG_Z] = f[FLAG_Z];
        nf[FLAG_C] = (rq.req_type == OP_SCF) ? 1'b1 : ~cin;
      end
      // decimal adjust: add side may set carry, subtract side keeps it
      OP_DAA: begin
        c  = cin;
        r8 = a8;
        if (!f[FLAG_N]) begin
          if (c || r8 > DAA_HI_MAX) begin
            r8 = r8 + DAA_HI_ADJ;
            c  = 1'b1;
          end
          if (f[FLAG_H] || r8[3:0] > DAA_LO_MAX) r8 = r8 + DAA_LO_ADJ;
        end else begin
          if (c) r8 = r8 - DAA_HI_ADJ;
          if (f[FLAG_H]) r8 = r8 - DAA_LO_ADJ;
        end
        res = {8'h00, r8};
        nf  = '0;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = f[FLAG_N];
        nf[FLAG_C] = c;
      end
      OP_ADD16: begin
        sum17 = {1'b0, a16} + {1'b0, b16};
        sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        res = sum17[15:0];
        nf  = '0;
        nf[FLAG_Z] = f[FLAG_Z];
        nf[FLAG_H] = sum13[12];
        nf[FLAG_C] = sum17[16];
      end
      OP_INC16: res = a16 + 16'd1;
      OP_DEC16: res = a16 - 16'd1;
      default: begin
        res = a16;
        nf  = f;
      end
    endcase
    rsp.result    = res;
    rsp.flags_out = nf;
    return rsp;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // operand with a bias toward carry and zero boundaries
  function automatic logic [15:0] pick_operand();
    logic [15:0] corners[12];
    corners = '{16'h0000, 16'h0001, 16'h000F, 16'h0010, 16'h007F, 16'h0080,
                16'h0099, 16'h00FF, 16'h0100, 16'h0FFF, 16'h1000, 16'hFFFF};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 11)];
    return 16'($urandom);
  endfunction

  function automatic alu_req_t mk_req(logic [4:0] op, logic [15:0] a, logic [15:0] b,
                                      logic [3:0] f);
    alu_req_t rq;
    rq.req_type  = op;
    rq.operand_a = a;
    rq.operand_b = b;
    rq.flags_in  = f;
    return rq;
  endfunction

  task automatic queue_random_reqs(int unsigned n);
    logic [4:0] op;
    for (int unsigned i = 0; i < n; i++) begin
      // a few unused codes, the rest spread over every operation
      if ($urandom_range(0, 24) == 0) op = 5'($urandom_range(OP_LAST_USED + 1, OP_CODE_MAX));
      else op = 5'($urandom_range(0, OP_LAST_USED));
      req_q.push_back(mk_req(op, pick_operand(), pick_operand(), 4'($urandom)));
    end
  endtask

  // wait until every queued request went in and every response came back
  task automatic drain();
    while (req_q.size() != 0 || in_tvalid || owed_rsp_q.size() != 0) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) owed_rsp_q.push_back(sm83_alu_result(cur_req));
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          cur_req   <= req_q[0];
          in_tuser  <= req_q[0].req_type;
          in_tdata  <= {4'h0, req_q[0].flags_in, req_q[0].operand_b, req_q[0].operand_a};
          in_tvalid <= 1'b1;
          void'(req_q.pop_front());
          send_gap  <= (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // response side ready, with random stalls and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD_LEN;
      out_tready     <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 30) begin
      stall_left <= pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // response checker
  always @(posedge clk) begin
    alu_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_rsp_q.size() == 0) begin
        err_cnt <= err_cnt + 1;
        if (err_cnt < MAX_REPORTS)
          $display("unexpected response: result %h flags %b", out_tdata[15:0], out_tdata[19:16]);
      end else begin
        want = owed_rsp_q.pop_front();
        if (out_tdata[15:0] != want.result || out_tdata[19:16] != want.flags_out) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < MAX_REPORTS)
            $display("mismatch: result exp %h got %h, flags exp %b got %b",
                     want.result, out_tdata[15:0], want.flags_out, out_tdata[19:16]);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("cpu_alu_with_flags_unit_tb failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners: every operation and flag edge
    req_q.push_back(mk_req(OP_ADD,   16'hAB01, 16'h12FF, 4'h0));
    req_q.push_back(mk_req(OP_ADC,   16'h000F, 16'h0000, 4'h1));
    req_q.push_back(mk_req(OP_ADC,   16'hFFFF, 16'hFFFF, 4'hF));
    req_q.push_back(mk_req(OP_SUB,   16'h5542, 16'h6642, 4'h0));
    req_q.push_back(mk_req(OP_SBC,   16'h0000, 16'h0000, 4'h1));
    req_q.push_back(mk_req(OP_SBC,   16'h0010, 16'h000F, 4'h0));
    req_q.push_back(mk_req(OP_AND,   16'hFFF0, 16'hFF0F, 4'h0));
    req_q.push_back(mk_req(OP_XOR,   16'h00FF, 16'hFFFF, 4'hF));
    req_q.push_back(mk_req(OP_OR,    16'h0000, 16'hFF00, 4'hF));
    req_q.push_back(mk_req(OP_CP,    16'h1234, 16'h0034, 4'h0));
    req_q.push_back(mk_req(OP_CP,    16'hFF00, 16'h0001, 4'h0));
    req_q.push_back(mk_req(OP_INC,   16'h00FF, 16'h0000, 4'h1));
    req_q.push_back(mk_req(OP_DEC,   16'h0010, 16'h0000, 4'h0));
    req_q.push_back(mk_req(OP_DEC,   16'h0001, 16'h0000, 4'h1));
    req_q.push_back(mk_req(OP_RLCA,  16'h0080, 16'h0000, 4'hE));
    req_q.push_back(mk_req(OP_RRCA,  16'h0001, 16'h0000, 4'hE));
    req_q.push_back(mk_req(OP_RLA,   16'h0080, 16'h0000, 4'h1));
    req_q.push_back(mk_req(OP_RRA,   16'h0001, 16'h0000, 4'h1));
    req_q.push_back(mk_req(OP_CPL,   16'hAA55, 16'h0000, 4'h9));
    req_q.push_back(mk_req(OP_SCF,   16'hBEEF, 16'h0000, 4'hE));
    req_q.push_back(mk_req(OP_CCF,   16'hCAFE, 16'h0000, 4'h9));
    req_q.push_back(mk_req(OP_DAA,   16'h009A, 16'h0000, 4'h0));
    req_q.push_back(mk_req(OP_DAA,   16'h0000, 16'h0000, 4'h7));
    req_q.push_back(mk_req(OP_ADD16, 16'h0FFF, 16'h0001, 4'h8));
    req_q.push_back(mk_req(OP_ADD16, 16'hFFFF, 16'h0001, 4'h0));
    req_q.push_back(mk_req(OP_INC16, 16'hFFFF, 16'h0000, 4'hA));
    req_q.push_back(mk_req(OP_DEC16, 16'h0000, 16'h0000, 4'h5));
    req_q.push_back(mk_req(OP_LAST_USED + 5'd1, 16'h8001, 16'h7FFE, 4'h6));
    req_q.push_back(mk_req(OP_CODE_MAX,         16'h7FFE, 16'h8001, 4'h9));
    drain();

    // random traffic with idling on both sides
    queue_random_reqs(300);
    drain();

    // back to back while the response side holds off, so the input stalls
    no_idle      <= 1'b1;
    long_hold_go <= 1'b1;
    queue_random_reqs(150);
    drain();
    no_idle <= 1'b0;

    queue_random_reqs(350);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_cnt == 0 && owed_rsp_q.size() == 0) begin
      $display("cpu_alu_with_flags_unit_tb passed");
    end else begin
      $display("cpu_alu_with_flags_unit_tb failed");
    end
    $finish;
  end

endmodule
